[sv/mqtt_receive_parser_assert.svh]
// Assertion helpers for the receive parser.
// Both sample on clock and are switched off while reset is high.
`ifndef MQTT_RECEIVE_PARSER_ASSERT_SVH
`define MQTT_RECEIVE_PARSER_ASSERT_SVH

// Same-cycle implication.
`define MQTTRX_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MQTTRX_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/mqttrx_pkg.sv]
`default_nettype none

package mqttrx_pkg;

   // Result kinds
   localparam logic [1:0] KIND_TOPIC   = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_EVENT   = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   // Control packet types
   localparam logic [3:0] PT_CONNACK    = 4'd2;
   localparam logic [3:0] PT_PUBLISH    = 4'd3;
   localparam logic [3:0] PT_PUBACK     = 4'd4;
   localparam logic [3:0] PT_SUBACK     = 4'd9;
   localparam logic [3:0] PT_UNSUBACK   = 4'd11;
   localparam logic [3:0] PT_PINGRESP   = 4'd13;
   localparam logic [3:0] PT_DISCONNECT = 4'd14;

   // Input command codes
   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   // Maximum length of the remaining-length varint, in bytes
   localparam logic [2:0] VARINT_MAX_BYTES = 3'd4;

   // Width of the running remaining-length accumulator
   localparam int unsigned ACCUM_W = 28;

   // One result item
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic        field_end;
      logic [3:0]  event_type;
      logic [15:0] packet_id;
      logic [9:0]  payload_length;
      logic        link_up;
      logic        run_last;
   } result_type;

endpackage

`default_nettype wire

[sv/mqtt_receive_parser.sv]
`default_nettype none

// Receive parser for a byte stream carrying MQTT 3.1.1 control packets.
// Input channel req_*: one item per byte; req_tuser is the command (0 = received
// byte in req_tdata, 1 = connection restart that clears the parser and the
// link flag without giving a result).
// Result channel rsp_*: topic bytes, payload bytes, packet events and protocol
// errors, kind in rsp_tuser; rsp_tlast marks the last result caused by a byte.
// A byte gives zero, one or two results.
// A result is written to the result queue as its byte is accepted and is offered
// once the older results have left. Throughput: one byte per cycle while the queue
// has room. The parser state updates in the accept cycle, and results go into a
// four-entry result queue, one result leaving per cycle while the receiver is ready.
// req_tready is high while the queue has room for two results, so bytes keep
// flowing while older results wait.
// When the receiver stalls, results stay queued and the input stalls once fewer
// than two queue slots are free; nothing is dropped.
// Reset empties the queue, returns the parser to the fixed-header phase and
// drops the link flag; no clearing pass is needed.
module mqtt_receive_parser #(
   parameter int unsigned MAX_PACKET  = 768,
   parameter int unsigned TOPIC_CAP   = 64,
   parameter int unsigned PAYLOAD_CAP = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] data_byte, [8] field_end, [12:9] event_type, [28:13] packet_id,
   // [38:29] payload_length, [39] link_up
   output logic [39:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast    // run_last
);

   `include "mqtt_receive_parser_assert.svh"

   localparam int unsigned BODY_W  = $clog2(MAX_PACKET + 1);
   localparam int unsigned TOPIC_W = $clog2(TOPIC_CAP);
   localparam int unsigned DEPTH   = 4;
   localparam int unsigned PTR_W   = $clog2(DEPTH);
   localparam int unsigned ACW     = mqttrx_pkg::ACCUM_W;

   typedef enum logic [2:0] {
      PH_HEADER    = 3'd0,
      PH_LENGTH    = 3'd1,
      PH_SKIP      = 3'd2,
      PH_FIELD     = 3'd3,
      PH_TOPIC_LEN = 3'd4,
      PH_TOPIC     = 3'd5,
      PH_PUB_ID    = 3'd6,
      PH_PAYLOAD   = 3'd7
   } phase_type;

   // Parser state
   phase_type          phase_ff, phase_in;
   logic [3:0]         pkt_type_ff, pkt_type_in;
   logic [1:0]         qos_ff, qos_in;
   logic [ACW-1:0]     accum_ff, accum_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [BODY_W-1:0]  body_ff, body_in;
   logic [TOPIC_W-1:0] topic_ff, topic_in;
   logic [15:0]        id_ff, id_in;
   logic               conn_ff, conn_in;

   // Result queue
   mqttrx_pkg::result_type fifo_mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]     fill_ff, fill_in;

   logic                   accept, pop;
   logic [1:0]             n_push;
   mqttrx_pkg::result_type res0, res1, head;

   assign req_tready = fill_ff <= (PTR_W + 1)'(DEPTH - 2);
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = fill_ff != '0;
   assign pop        = rsp_tvalid & rsp_tready;

   // Decode one byte against the current state
   always_comb begin
      logic [7:0]         b;
      logic [2:0]         cnt_inc;
      logic [ACW-1:0]     shifted;
      logic [ACW-1:0]     accum_new;
      logic [BODY_W-1:0]  body_dec;
      logic [TOPIC_W-1:0] topic_dec;
      logic [15:0]        id_new;
      logic [16:0]        need;
      logic [16:0]        plen;
      logic               fail;
      logic               do_fin;
      logic               data_vld;
      logic               evt_vld;
      mqttrx_pkg::result_type data_res;
      mqttrx_pkg::result_type evt_res;

      b         = req_tdata;
      cnt_inc   = cnt_ff + 3'd1;
      accum_new = accum_ff;
      body_dec  = (body_ff != '0) ? body_ff - BODY_W'(1) : body_ff;
      topic_dec = (topic_ff != '0) ? topic_ff - TOPIC_W'(1) : topic_ff;
      id_new    = {id_ff[7:0], b};
      need      = {1'b0, id_new} + ((qos_ff != 2'd0) ? 17'd2 : 17'd0);
      plen      = 17'(body_dec) - need;
      fail      = 1'b0;
      do_fin    = 1'b0;
      data_vld  = 1'b0;
      evt_vld   = 1'b0;
      data_res  = '0;
      evt_res   = '0;

      // Place the 7 payload bits of a varint byte
      case (cnt_ff[1:0])
         2'd0:    shifted = ACW'(b[6:0]);
         2'd1:    shifted = ACW'(b[6:0]) << 7;
         2'd2:    shifted = ACW'(b[6:0]) << 14;
         default: shifted = ACW'(b[6:0]) << 21;
      endcase

      phase_in    = phase_ff;
      pkt_type_in = pkt_type_ff;
      qos_in      = qos_ff;
      accum_in    = accum_ff;
      cnt_in      = cnt_ff;
      body_in     = body_ff;
      topic_in    = topic_ff;
      id_in       = id_ff;
      conn_in     = conn_ff;

      if (accept && req_tuser == mqttrx_pkg::CMD_RESTART) begin
         // Restart: clear parser and link flag
         phase_in = PH_HEADER;
         accum_in = '0;
         cnt_in   = '0;
         body_in  = '0;
         topic_in = '0;
         id_in    = '0;
         conn_in  = 1'b0;
      end else if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               pkt_type_in = b[7:4];
               qos_in      = b[2:1];
               accum_in    = '0;
               cnt_in      = '0;
               phase_in    = PH_LENGTH;
            end
            PH_LENGTH: begin
               accum_new = accum_ff | shifted;
               accum_in  = accum_new;
               cnt_in    = cnt_inc;
               if (b[7]) begin
                  if (cnt_inc >= mqttrx_pkg::VARINT_MAX_BYTES) begin
                     fail = 1'b1;
                  end
               end else if (accum_new > ACW'(MAX_PACKET)) begin
                  fail = 1'b1;
               end else begin
                  body_in = accum_new[BODY_W-1:0];
                  cnt_in  = '0;
                  id_in   = '0;
                  if (pkt_type_ff inside {mqttrx_pkg::PT_CONNACK, mqttrx_pkg::PT_PUBACK,
                                          mqttrx_pkg::PT_SUBACK, mqttrx_pkg::PT_UNSUBACK}) begin
                     if (accum_new < ACW'(2)) fail = 1'b1;
                     else phase_in = PH_FIELD;
                  end else if (pkt_type_ff == mqttrx_pkg::PT_PUBLISH) begin
                     if (accum_new < ACW'(2)) fail = 1'b1;
                     else phase_in = PH_TOPIC_LEN;
                  end else begin
                     phase_in = PH_SKIP;
                     if (accum_new == '0) do_fin = 1'b1;
                  end
               end
            end
            default: begin
               // Body byte
               body_in = body_dec;
               case (phase_ff)
                  PH_FIELD: begin
                     id_in  = id_new;
                     cnt_in = cnt_inc;
                     if (cnt_inc >= 3'd2) begin
                        if (pkt_type_ff == mqttrx_pkg::PT_CONNACK && id_new != 16'd0) begin
                           fail = 1'b1;
                        end else begin
                           phase_in = PH_SKIP;
                        end
                     end
                  end
                  PH_TOPIC_LEN: begin
                     id_in  = id_new;
                     cnt_in = cnt_inc;
                     if (cnt_inc >= 3'd2) begin
                        if (id_new == 16'd0 || id_new >= 16'(TOPIC_CAP)
                            || need > 17'(body_dec)) begin
                           fail = 1'b1;
                        end else if (plen >= 17'(PAYLOAD_CAP)) begin
                           fail = 1'b1;
                        end else begin
                           topic_in = id_new[TOPIC_W-1:0];
                           accum_in = ACW'(plen);
                           phase_in = PH_TOPIC;
                        end
                     end
                  end
                  PH_TOPIC: begin
                     topic_in           = topic_dec;
                     data_vld           = 1'b1;
                     data_res.kind      = mqttrx_pkg::KIND_TOPIC;
                     data_res.data_byte = b;
                     data_res.field_end = topic_dec == '0;
                     if (topic_dec == '0) begin
                        cnt_in   = '0;
                        phase_in = (qos_ff != 2'd0) ? PH_PUB_ID : PH_PAYLOAD;
                     end
                  end
                  PH_PUB_ID: begin
                     cnt_in = cnt_inc;
                     if (cnt_inc >= 3'd2) phase_in = PH_PAYLOAD;
                  end
                  PH_PAYLOAD: begin
                     data_vld           = 1'b1;
                     data_res.kind      = mqttrx_pkg::KIND_PAYLOAD;
                     data_res.data_byte = b;
                     data_res.field_end = body_dec == '0;
                  end
                  default: begin
                     // Skip unused body bytes
                  end
               endcase
               if (!fail && body_dec == '0) do_fin = 1'b1;
            end
         endcase

         // Complete the packet and raise its event
         if (do_fin) begin
            phase_in           = PH_HEADER;
            evt_res.kind       = mqttrx_pkg::KIND_EVENT;
            evt_res.event_type = pkt_type_ff;
            case (pkt_type_ff) inside
               mqttrx_pkg::PT_CONNACK: begin
                  conn_in = 1'b1;
                  evt_vld = 1'b1;
               end
               mqttrx_pkg::PT_PUBLISH: begin
                  evt_vld                = 1'b1;
                  evt_res.payload_length = accum_in[9:0];
               end
               mqttrx_pkg::PT_PUBACK, mqttrx_pkg::PT_SUBACK, mqttrx_pkg::PT_UNSUBACK: begin
                  evt_vld           = 1'b1;
                  evt_res.packet_id = id_in;
               end
               mqttrx_pkg::PT_PINGRESP: begin
                  evt_vld = 1'b1;
               end
               mqttrx_pkg::PT_DISCONNECT: begin
                  conn_in = 1'b0;
                  evt_vld = 1'b1;
               end
               default: begin
                  // Skipped type: no event
               end
            endcase
         end

         // Drop the packet on any malformation
         if (fail) begin
            evt_vld            = 1'b1;
            evt_res            = '0;
            evt_res.kind       = mqttrx_pkg::KIND_ERROR;
            evt_res.event_type = pkt_type_ff;
            conn_in            = 1'b0;
            phase_in           = PH_HEADER;
            accum_in           = '0;
            cnt_in             = '0;
            body_in            = '0;
            topic_in           = '0;
            id_in              = '0;
         end
      end

      // Order the results: data byte first, then event or error
      n_push           = 2'(data_vld) + 2'(evt_vld);
      res0             = data_vld ? data_res : evt_res;
      res0.link_up     = conn_in;
      res0.run_last    = n_push == 2'd1;
      res1             = evt_res;
      res1.link_up     = conn_in;
      res1.run_last    = 1'b1;
   end

   assign fill_in = fill_ff + (PTR_W + 1)'(n_push) - (PTR_W + 1)'(pop);

   // Hold parser state and the result queue
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         pkt_type_ff <= '0;
         qos_ff      <= '0;
         accum_ff    <= '0;
         cnt_ff      <= '0;
         body_ff     <= '0;
         topic_ff    <= '0;
         id_ff       <= '0;
         conn_ff     <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fill_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         pkt_type_ff <= pkt_type_in;
         qos_ff      <= qos_in;
         accum_ff    <= accum_in;
         cnt_ff      <= cnt_in;
         body_ff     <= body_in;
         topic_ff    <= topic_in;
         id_ff       <= id_in;
         conn_ff     <= conn_in;
         fill_ff     <= fill_in;
         if (n_push != 2'd0) begin
            fifo_mem[wr_ptr_ff] <= res0;
         end
         if (n_push == 2'd2) begin
            fifo_mem[wr_ptr_ff + PTR_W'(1)] <= res1;
         end
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(n_push);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   // Present the oldest queued result
   assign head      = fifo_mem[rd_ptr_ff];
   assign rsp_tdata = {head.link_up, head.payload_length, head.packet_id,
                       head.event_type, head.field_end, head.data_byte};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.run_last;

   `MQTTRX_ASSERT_NOW(a_fill_in_range, 1'b1, fill_ff <= (PTR_W + 1)'(DEPTH), "result queue overfilled")
   `MQTTRX_ASSERT_NOW(a_error_alone, rsp_tvalid && rsp_tuser == mqttrx_pkg::KIND_ERROR, rsp_tlast, "error result not last of its byte")
   `MQTTRX_ASSERT_NEXT(a_restart_drops_link, accept && req_tuser == mqttrx_pkg::CMD_RESTART, !conn_ff && phase_ff == PH_HEADER, "restart left parser active")

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   localparam int unsigned MAX_PACKET  = 768;
   localparam int unsigned TOPIC_CAP   = 64;
   localparam int unsigned PAYLOAD_CAP = 256;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned LONG_HOLD   = 500;
   localparam logic [3:0] SKIPPED_TYPES [9] = '{4'd0, 4'd1, 4'd5, 4'd6, 4'd7, 4'd8, 4'd10,
                                                4'd12, 4'd15};
   localparam logic [3:0] ACK_TYPES [3]   = '{mqttrx_pkg::PT_PUBACK, mqttrx_pkg::PT_SUBACK,
                                              mqttrx_pkg::PT_UNSUBACK};
   localparam logic [3:0] SHORT_TYPES [5] = '{mqttrx_pkg::PT_CONNACK, mqttrx_pkg::PT_PUBLISH,
                                              mqttrx_pkg::PT_PUBACK, mqttrx_pkg::PT_SUBACK,
                                              mqttrx_pkg::PT_UNSUBACK};

   // Parser phases of the expected-result model
   typedef enum logic [2:0] {
      PH_HEADER, PH_LENGTH, PH_SKIP, PH_FIELD, PH_TOPIC_LEN, PH_TOPIC, PH_PUB_ID, PH_PAYLOAD
   } parse_phase_type;

   // Faults that a generated PUBLISH may carry
   typedef enum int unsigned {
      FAULT_NONE, FAULT_EMPTY_TOPIC, FAULT_LONG_TOPIC, FAULT_BIG_PAYLOAD, FAULT_SHORT_BODY
   } publish_fault_type;

   // Tracks the parser state from accepted items and checks every result against it
   class mqtt_rx_scoreboard;
      mqttrx_pkg::result_type pending_results[$];
      mqttrx_pkg::result_type step_results[$];
      int unsigned     errors;

      parse_phase_type phase;
      logic [3:0]      ptype;
      logic [1:0]      qos;
      logic [27:0]     length_sum;
      logic [2:0]      byte_count;
      logic [9:0]      body_left;
      logic [15:0]     topic_left;
      logic [15:0]     id_value;
      logic            link;

      function new();
         errors = 0;
         ptype  = '0;
         qos    = '0;
         link   = 1'b0;
         clear_parser();
      endfunction

      function void clear_parser();
         phase      = PH_HEADER;
         length_sum = '0;
         byte_count = '0;
         body_left  = '0;
         topic_left = '0;
         id_value   = '0;
      endfunction

      function void emit(logic [1:0] kind, logic [7:0] data, logic fend, logic [3:0] ev,
                         logic [15:0] pid, logic [9:0] plen);
         mqttrx_pkg::result_type r;
         r                = '0;
         r.kind           = kind;
         r.data_byte      = data;
         r.field_end      = fend;
         r.event_type     = ev;
         r.packet_id      = pid;
         r.payload_length = plen;
         step_results.push_back(r);
      endfunction

      // Malformed input: report, drop the link and go back to the fixed header
      function void raise_error();
         emit(mqttrx_pkg::KIND_ERROR, 8'h00, 1'b0, ptype, 16'h0000, 10'h000);
         link = 1'b0;
         clear_parser();
      endfunction

      // Packet body fully consumed
      function void close_packet();
         case (ptype)
            mqttrx_pkg::PT_CONNACK: begin
               link = 1'b1;
               emit(mqttrx_pkg::KIND_EVENT, 8'h00, 1'b0, mqttrx_pkg::PT_CONNACK, 16'h0000,
                    10'h000);
            end
            mqttrx_pkg::PT_PUBLISH:
               emit(mqttrx_pkg::KIND_EVENT, 8'h00, 1'b0, mqttrx_pkg::PT_PUBLISH, 16'h0000,
                    length_sum[9:0]);
            mqttrx_pkg::PT_PUBACK, mqttrx_pkg::PT_SUBACK, mqttrx_pkg::PT_UNSUBACK:
               emit(mqttrx_pkg::KIND_EVENT, 8'h00, 1'b0, ptype, id_value, 10'h000);
            mqttrx_pkg::PT_PINGRESP:
               emit(mqttrx_pkg::KIND_EVENT, 8'h00, 1'b0, mqttrx_pkg::PT_PINGRESP, 16'h0000,
                    10'h000);
            mqttrx_pkg::PT_DISCONNECT: begin
               link = 1'b0;
               emit(mqttrx_pkg::KIND_EVENT, 8'h00, 1'b0, mqttrx_pkg::PT_DISCONNECT, 16'h0000,
                    10'h000);
            end
            default: ;
         endcase
         phase = PH_HEADER;
      endfunction

      // Advance the parser by one accepted item and queue the results it gives
      function void note_rx_item(logic cmd, logic [7:0] b);
         int unsigned need;
         mqttrx_pkg::result_type r;
         step_results.delete();
         if (cmd == mqttrx_pkg::CMD_RESTART) begin
            clear_parser();
            link = 1'b0;
            return;
         end
         case (phase)
            PH_HEADER: begin
               ptype      = b[7:4];
               qos        = b[2:1];
               length_sum = '0;
               byte_count = '0;
               phase      = PH_LENGTH;
            end
            PH_LENGTH: begin
               byte_count = byte_count + 1;
               length_sum = length_sum | (28'(b[6:0]) << (7 * (byte_count - 1)));
               if (b[7]) begin
                  if (byte_count >= mqttrx_pkg::VARINT_MAX_BYTES) raise_error();
               end else if (length_sum > MAX_PACKET) begin
                  raise_error();
               end else begin
                  body_left  = length_sum[9:0];
                  byte_count = '0;
                  id_value   = '0;
                  if (ptype == mqttrx_pkg::PT_CONNACK || ptype == mqttrx_pkg::PT_PUBACK ||
                      ptype == mqttrx_pkg::PT_SUBACK || ptype == mqttrx_pkg::PT_UNSUBACK) begin
                     if (length_sum < 2) raise_error();
                     else phase = PH_FIELD;
                  end else if (ptype == mqttrx_pkg::PT_PUBLISH) begin
                     if (length_sum < 2) raise_error();
                     else phase = PH_TOPIC_LEN;
                  end else begin
                     phase = PH_SKIP;
                     if (length_sum == 0) close_packet();
                  end
               end
            end
            default: begin
               if (body_left != 0) body_left = body_left - 1;
               case (phase)
                  PH_FIELD: begin
                     id_value   = {id_value[7:0], b};
                     byte_count = byte_count + 1;
                     if (byte_count >= 2) begin
                        if (ptype == mqttrx_pkg::PT_CONNACK && id_value != 16'h0000)
                           raise_error();
                        else phase = PH_SKIP;
                     end
                  end
                  PH_TOPIC_LEN: begin
                     id_value   = {id_value[7:0], b};
                     byte_count = byte_count + 1;
                     if (byte_count >= 2) begin
                        topic_left = id_value;
                        need = topic_left + ((qos != 2'd0) ? 2 : 0);
                        if (topic_left == 0 || topic_left >= TOPIC_CAP || need > body_left)
                           raise_error();
                        else if (body_left - need >= PAYLOAD_CAP)
                           raise_error();
                        else begin
                           length_sum = 28'(body_left - need);
                           phase      = PH_TOPIC;
                        end
                     end
                  end
                  PH_TOPIC: begin
                     if (topic_left != 0) topic_left = topic_left - 1;
                     emit(mqttrx_pkg::KIND_TOPIC, b, topic_left == 0, 4'h0, 16'h0000, 10'h000);
                     if (topic_left == 0) begin
                        byte_count = '0;
                        phase      = (qos != 2'd0) ? PH_PUB_ID : PH_PAYLOAD;
                     end
                  end
                  PH_PUB_ID: begin
                     byte_count = byte_count + 1;
                     if (byte_count >= 2) phase = PH_PAYLOAD;
                  end
                  PH_PAYLOAD:
                     emit(mqttrx_pkg::KIND_PAYLOAD, b, body_left == 0, 4'h0, 16'h0000, 10'h000);
                  default: ;
               endcase
               if (body_left == 0 && phase != PH_HEADER) close_packet();
            end
         endcase
         // Link flag and end-of-run mark apply to the whole step
         foreach (step_results[i]) begin
            r          = step_results[i];
            r.link_up  = link;
            r.run_last = (i == step_results.size() - 1);
            pending_results.push_back(r);
         end
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
         if (seen !== want) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            errors++;
         end
      endfunction

      function void check_result(mqttrx_pkg::result_type seen);
         mqttrx_pkg::result_type want;
         if (pending_results.size() == 0) begin
            $error("result with nothing expected: kind %0d data %0h", seen.kind,
                   seen.data_byte);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("kind", want.kind, seen.kind);
         compare_field("data_byte", want.data_byte, seen.data_byte);
         compare_field("field_end", want.field_end, seen.field_end);
         compare_field("event_type", want.event_type, seen.event_type);
         compare_field("packet_id", want.packet_id, seen.packet_id);
         compare_field("payload_length", want.payload_length, seen.payload_length);
         compare_field("link_up", want.link_up, seen.link_up);
         compare_field("run_last", want.run_last, seen.run_last);
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = mqttrx_pkg::CMD_BYTE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   mqtt_rx_scoreboard board;
   bit [7:0]    frame[$];
   int unsigned items_sent    = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned cycle_count   = 0;
   int unsigned hold_left     = 0;
   logic        hold_go       = 1'b0;
   logic        hold_done     = 1'b0;

   mqtt_receive_parser #(
      .MAX_PACKET  (MAX_PACKET),
      .TOPIC_CAP   (TOPIC_CAP),
      .PAYLOAD_CAP (PAYLOAD_CAP)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: random stalls, plus one long hold-off when asked for
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= LONG_HOLD;
         hold_done  <= 1'b1;
      end else
         rsp_tready <= ($urandom_range(99, 0) >= stall_pct);
   end

   // Watch both channels: check results, then note the accepted item
   always @(posedge clock) begin
      mqttrx_pkg::result_type seen;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen.kind           = rsp_tuser;
            seen.data_byte      = rsp_tdata[7:0];
            seen.field_end      = rsp_tdata[8];
            seen.event_type     = rsp_tdata[12:9];
            seen.packet_id      = rsp_tdata[28:13];
            seen.payload_length = rsp_tdata[38:29];
            seen.link_up        = rsp_tdata[39];
            seen.run_last       = rsp_tlast;
            board.check_result(seen);
         end
         if (req_tvalid && req_tready) board.note_rx_item(req_tuser, req_tdata);
      end
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[mqtt_receive_parser] ERROR");
         $finish;
      end
   end

   // Offer one item, idling first at random, and hold it until accepted
   task automatic send_item(input logic cmd, input logic [7:0] b);
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= b;
      do @(posedge clock); while (req_tready !== 1'b1);
      items_sent++;
   endtask

   // Send the first keep bytes of the frame and drop the rest
   task automatic send_frame(input int unsigned keep);
      foreach (frame[i])
         if (i < keep) send_item(mqttrx_pkg::CMD_BYTE, frame[i]);
      frame.delete();
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Remaining-length varint, optionally padded out to four bytes
   function automatic void put_length(int unsigned len, bit pad);
      int unsigned rest;
      int unsigned first;
      first = frame.size();
      rest  = len;
      do begin
         frame.push_back({(rest > 127) ? 1'b1 : 1'b0, rest[6:0]});
         rest = rest >> 7;
      end while (rest != 0);
      if (pad)
         while (frame.size() - first < 4) begin
            frame[frame.size() - 1] = frame[frame.size() - 1] | 8'h80;
            frame.push_back(8'h00);
         end
   endfunction

   // PUBLISH with random flags; a faulty one stops after the topic length
   function automatic void build_publish(bit broken);
      logic [3:0]        flags;
      int unsigned       tlen, plen, idlen, rl;
      publish_fault_type fault;
      flags = 4'($urandom);
      idlen = (flags[2:1] != 2'd0) ? 2 : 0;
      tlen  = ($urandom_range(9, 0) == 0) ? $urandom_range(63, 1) : $urandom_range(6, 1);
      plen  = ($urandom_range(39, 0) == 0) ? $urandom_range(255, 200) : $urandom_range(10, 0);
      fault = broken ? publish_fault_type'($urandom_range(4, 1)) : FAULT_NONE;
      case (fault)
         FAULT_EMPTY_TOPIC: tlen = 0;
         FAULT_LONG_TOPIC:  tlen = $urandom_range(100, 64);
         FAULT_BIG_PAYLOAD: plen = $urandom_range(300, 256);
         default: ;
      endcase
      rl = 2 + tlen + idlen + plen;
      if (fault == FAULT_SHORT_BODY) rl = 2 + tlen + idlen - $urandom_range(tlen + idlen, 1);
      frame.push_back({mqttrx_pkg::PT_PUBLISH, flags});
      put_length(rl, $urandom_range(7, 0) == 0);
      frame.push_back(tlen[15:8]);
      frame.push_back(tlen[7:0]);
      if (fault == FAULT_NONE) begin
         repeat (tlen) frame.push_back(8'($urandom));
         repeat (idlen) frame.push_back(8'($urandom));
         repeat (plen) frame.push_back(8'($urandom));
      end
   endfunction

   // CONNACK or an acknowledgement carrying a two-byte field
   function automatic void build_ack(logic [3:0] ptype, bit rejected);
      logic [15:0] field;
      int unsigned extra;
      extra = (!rejected && $urandom_range(3, 0) == 0) ? $urandom_range(3, 1) : 0;
      field = (ptype == mqttrx_pkg::PT_CONNACK) ? 16'h0000 : 16'($urandom);
      if (rejected)
         do field = 16'($urandom); while (field == 16'h0000);
      frame.push_back({ptype, 4'($urandom)});
      put_length(2 + extra, $urandom_range(7, 0) == 0);
      frame.push_back(field[15:8]);
      frame.push_back(field[7:0]);
      repeat (extra) frame.push_back(8'($urandom));
   endfunction

   function automatic void build_plain(logic [3:0] ptype, int unsigned body_len);
      frame.push_back({ptype, 4'($urandom)});
      put_length(body_len, $urandom_range(7, 0) == 0);
      repeat (body_len) frame.push_back(8'($urandom));
   endfunction

   // Length faults: oversize, a fifth varint byte, or a body too short to parse
   function automatic void build_bad_length();
      case ($urandom_range(2, 0))
         0: begin
            frame.push_back(8'($urandom));
            put_length(($urandom_range(3, 0) == 0) ?
                       $urandom_range(28'hFFFFFFF, MAX_PACKET + 1) :
                       $urandom_range(1500, MAX_PACKET + 1), 1'b0);
         end
         1: begin
            frame.push_back(8'($urandom));
            repeat (4) frame.push_back({1'b1, 7'($urandom)});
         end
         default: begin
            frame.push_back({SHORT_TYPES[$urandom_range(4, 0)], 4'($urandom)});
            put_length($urandom_range(1, 0), $urandom_range(3, 0) == 0);
         end
      endcase
   endfunction

   // Mostly well-formed packets, some broken; cut-short frames and noise are followed by a restart
   task automatic random_traffic(input int unsigned count);
      int unsigned stop_at;
      int unsigned pick;
      bit          cut;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99, 0);
         if (pick < 30) build_publish(1'b0);
         else if (pick < 37) build_publish(1'b1);
         else if (pick < 45) build_ack(mqttrx_pkg::PT_CONNACK, $urandom_range(5, 0) == 0);
         else if (pick < 60) build_ack(ACK_TYPES[$urandom_range(2, 0)], 1'b0);
         else if (pick < 65)
            build_plain(mqttrx_pkg::PT_PINGRESP,
                        ($urandom_range(4, 0) == 0) ? $urandom_range(3, 1) : 0);
         else if (pick < 69)
            build_plain(mqttrx_pkg::PT_DISCONNECT,
                        ($urandom_range(4, 0) == 0) ? $urandom_range(3, 1) : 0);
         else if (pick < 75)
            build_plain(SKIPPED_TYPES[$urandom_range(8, 0)], $urandom_range(6, 0));
         else if (pick < 81) build_bad_length();
         else if (pick < 88)
            repeat ($urandom_range(6, 1)) frame.push_back(8'($urandom));
         cut = (pick >= 81) || (pick < 75 && $urandom_range(9, 0) == 0);
         if (cut) begin
            send_frame($urandom_range(frame.size(), 0));
            send_item(mqttrx_pkg::CMD_RESTART, 8'($urandom));
         end else
            send_frame(frame.size());
      end
   endtask

   initial begin
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed packets
      frame = '{8'h20, 8'h02, 8'h00, 8'h00,                    // CONNACK accepted
                8'h30, 8'h04, 8'h00, 8'h01, 8'h61, 8'hFF,      // QoS 0, one-byte payload
                8'h3B, 8'h05, 8'h00, 8'h01, 8'h7A, 8'h12, 8'h34,  // QoS 1, empty payload
                8'h36, 8'h06, 8'h00, 8'h01, 8'h00, 8'hAB, 8'hCD, 8'h80, // QoS 3
                8'h40, 8'h02, 8'hFF, 8'hFF,                    // PUBACK, highest id
                8'h90, 8'h03, 8'h00, 8'h00, 8'h01,             // SUBACK, extra body byte
                8'hB0, 8'h02, 8'h80, 8'h01,                    // UNSUBACK
                8'hD0, 8'h80, 8'h80, 8'h80, 8'h00,             // PINGRESP, padded length
                8'hE0, 8'h00,                                  // DISCONNECT
                8'hF0, 8'h01, 8'h5A, 8'h00, 8'h00,             // skipped types
                8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF,             // fifth length byte
                8'h30, 8'h81, 8'h06,                           // just over the size limit
                8'h20, 8'h01,                                  // CONNACK body too short
                8'h20, 8'h02, 8'h00, 8'h00, 8'h21, 8'h02, 8'h01, 8'h00, // rejected CONNACK
                8'h30, 8'h02, 8'h00, 8'h00,                    // empty topic
                8'h30, 8'h42, 8'h00, 8'h40,                    // topic at the cap
                8'h32, 8'h04, 8'h00, 8'h02,                    // topic and id exceed body
                8'h30, 8'h83, 8'h02, 8'h00, 8'h01,             // payload at the cap
                8'h30, 8'h05, 8'h00};                          // cut short by a restart
      send_frame(frame.size());
      send_item(mqttrx_pkg::CMD_RESTART, 8'hFF);
      wait_results_drained();

      // No idling
      random_traffic(330);
      wait_results_drained();

      // Sender mostly idle
      send_idle_pct = 88;
      random_traffic(300);
      wait_results_drained();

      // Receiver mostly stalled
      send_idle_pct = 0;
      stall_pct    <= 88;
      random_traffic(300);
      wait_results_drained();

      // Light idling on both sides
      send_idle_pct = 13;
      stall_pct    <= 13;
      random_traffic(330);
      wait_results_drained();

      // Long receiver hold-off while the sender keeps pushing, to back up the input
      send_idle_pct = 0;
      stall_pct    <= 0;
      hold_go      <= 1'b1;
      random_traffic(60);
      wait_results_drained();

      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("[mqtt_receive_parser] OK");
      else
         $display("[mqtt_receive_parser] ERROR");
      $finish;
   end
endmodule

[sim.f]
+incdir+sv
sv/mqttrx_pkg.sv
sv/mqtt_receive_parser.sv
tb/sv/testbench.sv
